/* hdl/url_percent_decoder_assert.svh */
// assertion macros for the url percent decoder
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, off while reset is high
`define UPD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("url decoder check failed");
// checked property, also during reset
`define UPD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("url decoder check failed");
`else
`define UPD_ASSERT(lbl, clk, rst, prop)
`define UPD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hdl/upd_pkg.sv */
// shared types and constants of the url percent decoder
package upd_pkg;

   localparam int CAP_WIDTH = 13;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 13'd1024;

   localparam int FIFO_AW = 2;
   localparam int FIFO_DEPTH = 1 << FIFO_AW;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_TOO_LONG = 2'd1;
   localparam logic [1:0] ST_CUT_SHORT = 2'd2;
   localparam logic [1:0] ST_BAD_HEX = 2'd3;

   typedef enum logic [3:0] {
      PH_PLAIN = 4'b0001,
      PH_HIGH  = 4'b0010,
      PH_LOW   = 4'b0100,
      PH_BADHI = 4'b1000
   } phase_type;

   // classified character as it sits in the queue
   typedef struct packed {
      logic       is_end;
      logic       is_pct;
      logic       is_plus;
      logic       hex_ok;
      logic [3:0] hex_val;
      logic [7:0] raw;
   } token_type;

endpackage

/* hdl/upd_if.sv */
// request and response channel interfaces of the url percent decoder
interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_mark;

   modport source (output valid, output in_byte, output end_mark, input ready);
   modport sink (input valid, input in_byte, input end_mark, output ready);
endinterface

interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_end;
   logic [1:0] status;

   modport source (output valid, output out_byte, output is_end, output status,
                   input ready);
   modport sink (input valid, input out_byte, input is_end, input status,
                 output ready);
endinterface

/* hdl/url_percent_decoder.sv */
// top level of the streaming url percent decoder
//
//   channel   dir   beat contents                      handshake
//   req_ch    in    in_byte, end_mark                  valid / ready
//   rsp_ch    out   out_byte, is_end, status           valid / ready
//   csr       in    csr_wdata (out_capacity, 13 bits)  csr_we, no stall
//
// sustains one request beat per clock while the queue has room; a byte
// or end result leaves through the queue stage, then the result register
// the four-entry token queue lets the request side keep going for four
// beats while the response side is stalled
// reset empties the queue and the result register, clears the string state
// and sets out_capacity to 1024
module url_percent_decoder
   import upd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   upd_req_if.sink              req_ch,
   upd_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CAP_WIDTH-1:0] csr_wdata
);

   // destination size, terminator included; to be written only while idle, which the block does not enforce
   logic [CAP_WIDTH-1:0] csr_cap_ff, csr_cap_in;

   // classified beats on their way from front to back
   logic      push;
   token_type push_data;
   logic      fifo_full;
   logic      pop;
   logic      head_valid;
   token_type head_data;

   assign csr_cap_in = csr_we ? csr_wdata : csr_cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_cap_ff <= CAP_RESET;
      end else begin
         csr_cap_ff <= csr_cap_in;
      end
   end

   // front: takes a beat whenever the queue has room and tags '%', '+',
   // hex digits and end marks
   upd_front u_front (
      .req_ch    (req_ch),
      .fifo_full (fifo_full),
      .push      (push),
      .push_data (push_data)
   );

   // queue that decouples the two sides
   upd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // back: escape phases, capacity check, error latching and result beat;
   // tokens that give no result drain even while the output is stalled
   upd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .out_capacity (csr_cap_ff),
      .head_valid   (head_valid),
      .head_data    (head_data),
      .pop          (pop),
      .rsp_ch       (rsp_ch)
   );

endmodule

/* hdl/upd_front.sv */
// front end: accepts request beats and classifies each character
module upd_front
   import upd_pkg::*;
(
   upd_req_if.sink   req_ch,
   input  logic      fifo_full,
   output logic      push,
   output token_type push_data
);

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   logic [4:0] hex;

   assign hex = hex_decode(req_ch.in_byte);

   assign req_ch.ready = !fifo_full;
   assign push = req_ch.valid && !fifo_full;

   always_comb begin
      push_data.is_end  = req_ch.end_mark;
      push_data.is_pct  = (req_ch.in_byte == CHAR_PERCENT);
      push_data.is_plus = (req_ch.in_byte == CHAR_PLUS);
      push_data.hex_ok  = hex[4];
      push_data.hex_val = hex[3:0];
      push_data.raw     = req_ch.in_byte;
   end

endmodule

/* hdl/upd_fifo.sv */
// short token queue between front and back
`include "url_percent_decoder_assert.svh"
module upd_fifo
   import upd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output token_type head_data
);

   localparam logic [FIFO_AW:0] FULL_CNT = (FIFO_AW + 1)'(FIFO_DEPTH);

   token_type          store_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               do_pop;

   assign full = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data = store_ff[rd_ptr_ff];
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill level matches the pointer distance unless the queue is full
   `UPD_ASSERT(a_fifo_level, clock, reset,
      (count_ff == FULL_CNT) || (count_ff[FIFO_AW-1:0] == (wr_ptr_ff - rd_ptr_ff)))

endmodule

/* hdl/upd_back.sv */
// back end: escape state machine, byte count and result register
`include "url_percent_decoder_assert.svh"
module upd_back
   import upd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CAP_WIDTH-1:0] out_capacity,
   input  logic                 head_valid,
   input  token_type            head_data,
   output logic                 pop,
   upd_rsp_if.source            rsp_ch
);

   phase_type            phase_ff, phase_in;
   logic [3:0]           nibble_ff, nibble_in;
   logic [CAP_WIDTH-1:0] count_ff, count_in;
   logic [1:0]           err_ff, err_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_end_ff, rsp_end_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic       emit;
   logic [7:0] emit_byte;
   logic [1:0] emit_status;
   logic       cap_zero;
   logic       cap_full;
   logic       out_free;

   assign cap_zero = (out_capacity == '0);
   assign cap_full = cap_zero || (count_ff >= (out_capacity - 1'b1));
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      phase_in    = phase_ff;
      nibble_in   = nibble_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      emit        = 1'b0;
      emit_byte   = 8'd0;
      emit_status = ST_OK;
      if (head_data.is_end) begin
         emit = 1'b1;
         emit_status = err_ff;
         if (err_ff == ST_OK) begin
            if (cap_zero) begin
               emit_status = ST_TOO_LONG;
            end else if (phase_ff != PH_PLAIN) begin
               emit_status = ST_CUT_SHORT;
            end
         end
         phase_in  = PH_PLAIN;
         nibble_in = 4'd0;
         count_in  = '0;
         err_in    = ST_OK;
      end else if (err_ff == ST_OK) begin
         unique case (phase_ff)
            PH_PLAIN: begin
               if (cap_full) begin
                  err_in = ST_TOO_LONG;
               end else if (head_data.is_pct) begin
                  phase_in = PH_HIGH;
               end else begin
                  emit = 1'b1;
                  emit_byte = head_data.is_plus ? CHAR_SPACE : head_data.raw;
                  count_in = count_ff + 1'b1;
               end
            end
            PH_HIGH: begin
               nibble_in = head_data.hex_ok ? head_data.hex_val : 4'd0;
               phase_in  = head_data.hex_ok ? PH_LOW : PH_BADHI;
            end
            PH_LOW: begin
               phase_in = PH_PLAIN;
               if (!head_data.hex_ok) begin
                  err_in = ST_BAD_HEX;
               end else begin
                  emit = 1'b1;
                  emit_byte = {nibble_ff, head_data.hex_val};
                  count_in = count_ff + 1'b1;
               end
            end
            PH_BADHI: begin
               phase_in  = PH_PLAIN;
               nibble_in = 4'd0;
               err_in    = ST_BAD_HEX;
            end
            default: begin
               phase_in = PH_PLAIN;
            end
         endcase
      end
   end

   // tokens with no result never wait for the output register
   assign pop = head_valid && (!emit || out_free);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_status_in = rsp_status_ff;
      if (pop && emit) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = emit_byte;
         rsp_end_in    = head_data.is_end;
         rsp_status_in = emit_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PLAIN;
         nibble_ff    <= 4'd0;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff  <= phase_in;
            nibble_ff <= nibble_in;
            count_ff  <= count_in;
            err_ff    <= err_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.is_end   = rsp_end_ff;
   assign rsp_ch.status   = rsp_status_ff;

   // a latched error always leaves the escape machine in plain state
   `UPD_ASSERT(a_err_plain, clock, reset, (err_ff != ST_OK) |-> (phase_ff == PH_PLAIN))
   // end results carry a zero byte, byte results carry ok status
   `UPD_ASSERT(a_rsp_fields, clock, reset,
      rsp_valid_ff |-> (rsp_end_ff ? (rsp_byte_ff == 8'd0) : (rsp_status_ff == ST_OK)))
   // an end token always clears the string state
   `UPD_ASSERT_ALWAYS(a_end_clears, clock,
      (!reset && pop && head_data.is_end) |=> (err_ff == ST_OK && count_ff == '0))

endmodule

/* sim/tb.sv */
// self-checking testbench for the streaming url percent decoder
`timescale 1ns / 1ps

module tb;
   import upd_pkg::*;

   // one result beat as the decoder should send it
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] code;
   } decoded_type;

   // one row of the directed table; pinned rows carry the result typed in,
   // the others are checked against the decode predictor
   typedef struct packed {
      logic [7:0]  chr;
      logic        last;
      logic        pinned;
      logic        pin_any;
      decoded_type pin_want;
   } stim_row_type;

   localparam int CLK_HALF = 2;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 12;      // time to empty the queue and both stages, with margin
   localparam int CYCLE_LIMIT = 200000;
   localparam int N_PLAN = 25;
   localparam int N_PHASES = 9;
   localparam int PHASE_BEATS = 180;
   localparam int PHASE_STRINGS = 80;
   localparam int NO_IDLE_PHASE = 3;
   localparam decoded_type NONE = '0;

   localparam stim_row_type PLAN [N_PLAN] = '{
      // empty string right after reset closes clean
      '{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, ST_OK}},
      // plain byte, plus sign, zero byte and the top byte
      '{8'h61, 1'b0, 1'b1, 1'b1, '{8'h61, 1'b0, ST_OK}},
      '{CHAR_PLUS, 1'b0, 1'b1, 1'b1, '{CHAR_SPACE, 1'b0, ST_OK}},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'hFF, 1'b0, ST_OK}},
      // mixed-case escape to the top value
      '{CHAR_PERCENT, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h66, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h46, 1'b0, 1'b1, 1'b1, '{8'hFF, 1'b0, ST_OK}},
      // escape to zero
      '{CHAR_PERCENT, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h30, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h30, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      // upper-case letter then digit
      '{CHAR_PERCENT, 1'b0, 1'b0, 1'b0, NONE},
      '{8'h41, 1'b0, 1'b0, 1'b0, NONE},
      '{8'h39, 1'b0, 1'b0, 1'b0, NONE},
      // end beat with junk in the byte field
      '{8'hA5, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, ST_OK}},
      // string ends after the high digit
      '{CHAR_PERCENT, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h34, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, ST_CUT_SHORT}},
      // bad high digit then end: still reported as cut short
      '{CHAR_PERCENT, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h67, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, ST_CUT_SHORT}},
      // bad high digit followed by a low digit: bad hex
      '{CHAR_PERCENT, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h7A, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h31, 1'b0, 1'b1, 1'b0, NONE},
      '{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, ST_BAD_HEX}}
   };

   // capacity per random phase: zero, tiny ones that overflow often, middle ones,
   // and roomy ones where strings always fit
   localparam logic [CAP_WIDTH-1:0] PHASE_CAPS [N_PHASES] = '{
      13'd0, 13'd1, 13'd2, 13'd5, 13'd4096, 13'd13, 13'd4095, 13'd1024, 13'd40
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [CAP_WIDTH-1:0] csr_wdata;

   upd_req_if req_ch ();
   upd_rsp_if rsp_ch ();

   url_percent_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // decode predictor state, mirrors the string state of the block
   phase_type            scan_phase;
   logic [3:0]           hi_digit;
   logic [CAP_WIDTH-1:0] bytes_out;
   logic [1:0]           latched_err;
   logic [CAP_WIDTH-1:0] capacity;

   decoded_type decoded_q [$];  // decoded beats still owed by the block
   int mismatch_count = 0;
   int cycle_count = 0;
   int live_beats = 0;          // request beats sent so far
   int idle_pct = 17;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // hex digit value, -1 for anything that is not one
   function automatic int hex_digit(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   function automatic void clear_string();
      scan_phase = PH_PLAIN;
      hi_digit = '0;
      bytes_out = '0;
      latched_err = ST_OK;
   endfunction

   // advance the predictor by one request beat; returns 1 when a result is due
   function automatic bit decode_beat(input logic [7:0] c, input logic last,
                                      output decoded_type res);
      int v;
      res = '0;
      if (last) begin
         res.last = 1'b1;
         res.code = latched_err;
         if (latched_err == ST_OK) begin
            if (capacity == '0) res.code = ST_TOO_LONG;
            else if (scan_phase != PH_PLAIN) res.code = ST_CUT_SHORT;
         end
         clear_string();
         return 1'b1;
      end
      // after an error the rest of the string is swallowed
      if (latched_err != ST_OK) return 1'b0;
      v = hex_digit(c);
      case (scan_phase)
         PH_PLAIN: begin
            // capacity is checked as each token starts, terminator kept free
            if (capacity == '0 || bytes_out >= capacity - 13'd1) begin
               latched_err = ST_TOO_LONG;
               return 1'b0;
            end
            if (c == CHAR_PERCENT) begin
               scan_phase = PH_HIGH;
               return 1'b0;
            end
            bytes_out = bytes_out + 13'd1;
            res.data = (c == CHAR_PLUS) ? CHAR_SPACE : c;
            return 1'b1;
         end
         PH_HIGH: begin
            // a bad high digit is held back until the low digit arrives
            if (v < 0) begin
               hi_digit = '0;
               scan_phase = PH_BADHI;
            end else begin
               hi_digit = 4'(v);
               scan_phase = PH_LOW;
            end
            return 1'b0;
         end
         PH_LOW: begin
            scan_phase = PH_PLAIN;
            if (v < 0) begin
               latched_err = ST_BAD_HEX;
               return 1'b0;
            end
            bytes_out = bytes_out + 13'd1;
            res.data = {hi_digit, 4'(v)};
            return 1'b1;
         end
         default: begin
            scan_phase = PH_PLAIN;
            hi_digit = '0;
            latched_err = ST_BAD_HEX;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns mismatch: %s", $time, what);
   endtask

   // drive one request beat from a falling edge, wait for the handshake and
   // record what the decoder owes for it; returns at the next falling edge
   task automatic send_beat(input logic [7:0] chr, input logic last,
                            input bit pinned = 1'b0, input bit pin_any = 1'b0,
                            input decoded_type pin_want = '0);
      decoded_type want;
      bit any;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.in_byte = chr;
      req_ch.end_mark = last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      any = decode_beat(chr, last, want);
      if (pinned) begin
         any = pin_any;
         want = pin_want;
      end
      if (any) decoded_q.push_back(want);
      live_beats++;
      @(negedge clock);
   endtask

   // capacity only changes with the block idle: every owed beat has come and
   // any swallowed tokens have had time to leave the queue
   task automatic write_capacity(input logic [CAP_WIDTH-1:0] cap);
      req_ch.valid = 1'b0;
      while (decoded_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = cap;
      @(negedge clock);
      csr_we = 1'b0;
      csr_wdata = 13'($urandom_range(8191));
      capacity = cap;
   endtask

   function automatic logic [7:0] pick_hex_char();
      int k;
      k = $urandom_range(21);
      if (k < 10) return 8'h30 + 8'(k);
      if (k < 16) return 8'h61 + 8'(k - 10);
      return 8'h41 + 8'(k - 16);
   endfunction

   // non-hex character, often one sitting right next to a hex range
   function automatic logic [7:0] pick_bad_char();
      logic [7:0] c;
      case ($urandom_range(7))
         0: c = 8'h2F;
         1: c = 8'h3A;
         2: c = 8'h40;
         3: c = 8'h47;
         4: c = 8'h60;
         5: c = 8'h67;
         default: begin
            c = 8'($urandom_range(255));
            while (hex_digit(c) >= 0) c = 8'($urandom_range(255));
         end
      endcase
      return c;
   endfunction

   // one encoded string and its end beat; mostly well formed with random
   // content, with bad escapes, cut escapes and raw noise mixed in
   task automatic send_random_string();
      int n_tok;
      int pick;
      logic [7:0] chr;
      if ($urandom_range(99) < 4) begin
         n_tok = $urandom_range(10);
         repeat (n_tok) send_beat(8'($urandom_range(255)), 1'b0);
         send_beat(8'($urandom_range(255)), 1'b1);
         return;
      end
      n_tok = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(12);
      for (int t = 0; t < n_tok; t++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            chr = 8'($urandom_range(126, 32));
            if (chr == CHAR_PERCENT) chr = 8'h7E;
            send_beat(chr, 1'b0);
         end else if (pick < 53) begin
            send_beat(CHAR_PLUS, 1'b0);
         end else if (pick < 60) begin
            send_beat(8'($urandom_range(255)), 1'b0);
         end else if (pick < 86) begin
            send_beat(CHAR_PERCENT, 1'b0);
            send_beat(pick_hex_char(), 1'b0);
            send_beat(pick_hex_char(), 1'b0);
         end else if (pick < 94) begin
            // broken escape: bad high, bad low, or both
            send_beat(CHAR_PERCENT, 1'b0);
            case ($urandom_range(2))
               0: begin
                  send_beat(pick_bad_char(), 1'b0);
                  send_beat(pick_hex_char(), 1'b0);
               end
               1: begin
                  send_beat(pick_hex_char(), 1'b0);
                  send_beat(pick_bad_char(), 1'b0);
               end
               default: begin
                  send_beat(pick_bad_char(), 1'b0);
                  send_beat(pick_bad_char(), 1'b0);
               end
            endcase
         end else begin
            // escape cut off by the end beat
            send_beat(CHAR_PERCENT, 1'b0);
            if ($urandom_range(1) == 1) send_beat(pick_hex_char(), 1'b0);
            break;
         end
      end
      send_beat(8'($urandom_range(255)), 1'b1);
   endtask

   // result side stalls at random, except in the no-idle stretch
   always @(negedge clock) begin
      if (!reset) rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
   end

   // compare every result beat with the oldest owed one
   always @(posedge clock) begin : rsp_check
      decoded_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat byte %02h end %0b status %0d",
                                      rsp_ch.out_byte, rsp_ch.is_end, rsp_ch.status));
         end else begin
            want = decoded_q.pop_front();
            if (rsp_ch.out_byte !== want.data)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_ch.out_byte, want.data));
            if (rsp_ch.is_end !== want.last)
               report_mismatch($sformatf("is_end %0b, want %0b",
                                         rsp_ch.is_end, want.last));
            if (rsp_ch.status !== want.code)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_ch.status, want.code));
         end
      end
   end

   // a hung handshake or a lost beat ends here
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      req_ch.valid = 1'b0;
      req_ch.in_byte = '0;
      req_ch.end_mark = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      reset = 1'b1;
      capacity = CAP_RESET;
      clear_string();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table at the reset capacity
      for (int r = 0; r < N_PLAN; r++)
         send_beat(PLAN[r].chr, PLAN[r].last, PLAN[r].pinned, PLAN[r].pin_any,
                   PLAN[r].pin_want);

      // random phases, each at its own capacity; the capacity write drains
      // the block first, so the sender also sits out a full flush each time
      for (int p = 0; p < N_PHASES; p++) begin
         int start_beats;
         int strings;
         write_capacity(PHASE_CAPS[p]);
         idle_pct = (p == NO_IDLE_PHASE) ? 0 : 17;
         start_beats = live_beats;
         strings = 0;
         while (live_beats - start_beats < PHASE_BEATS && strings < PHASE_STRINGS) begin
            send_random_string();
            strings++;
         end
      end

      req_ch.valid = 1'b0;
      idle_pct = 17;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/upd_pkg.sv
hdl/upd_if.sv
hdl/upd_front.sv
hdl/upd_fifo.sv
hdl/upd_back.sv
hdl/url_percent_decoder.sv
sim/tb.sv
